### rtl/dsrq_pkg.sv
// ----------------------------------------------------------------------------
// dsrq_pkg: shared definitions for the deadline-sorted ready queue
// Sizes, command and status codes, entry and controller state types.
// ----------------------------------------------------------------------------
package dsrq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ID_W  = 8;
	localparam int DL_W  = 32;
	localparam int OCC_W = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef logic cmd_t;
	localparam cmd_t CMD_INSERT = 1'b0;
	localparam cmd_t CMD_REMOVE = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_DONE  = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WALK  = 6'b000010,
		ST_RHEAD = 6'b000100,
		ST_SHIFT = 6'b001000,
		ST_HEAD  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

### rtl/dsrq_if.sv
// ----------------------------------------------------------------------------
// dsrq_if: request and response channels of the ready queue
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface dsrq_req_if;
	logic                        valid;
	logic                        ready;
	dsrq_pkg::cmd_t              cmd;
	logic [dsrq_pkg::ID_W-1:0]   task_id;
	logic [dsrq_pkg::DL_W-1:0]   deadline;

	modport source (output valid, output cmd, output task_id, output deadline, input ready);
	modport sink   (input valid, input cmd, input task_id, input deadline, output ready);
endinterface

interface dsrq_rsp_if;
	logic                        valid;
	logic                        ready;
	dsrq_pkg::status_t           status;
	logic [dsrq_pkg::ID_W-1:0]   removed_id;
	logic                        head_valid;
	logic [dsrq_pkg::ID_W-1:0]   head_id;
	logic [dsrq_pkg::DL_W-1:0]   head_deadline;
	logic [dsrq_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, output status, output removed_id, output head_valid,
		output head_id, output head_deadline, output occupancy, input ready);
	modport sink   (input valid, input status, input removed_id, input head_valid,
		input head_id, input head_deadline, input occupancy, output ready);
endinterface

### rtl/deadline_sorted_ready_queue.sv
// ----------------------------------------------------------------------------
// deadline_sorted_ready_queue: earliest-deadline-first ready queue
// Entries sit in a single-port-read memory in deadline order; one comparator
// and one memory read/write per cycle walk the list on insert and remove.
// ----------------------------------------------------------------------------
//
//   channel | modport | payload
//   --------+---------+--------------------------------------------------------
//   req     | sink    | cmd, task_id, deadline
//   rsp     | source  | status, removed_id, head_valid, head_id, head_deadline,
//           |         | occupancy
//
// An insert moves each held entry with a later deadline back one place, a remove
// moves every remaining entry forward one place, and a rejected (full or empty)
// request only reads the head; the one memory read and write a cycle pace them all.
// After reset the queue is empty and ready at once; no clearing pass is made.
// A request is taken only when the controller is idle; a pending response is held
// in its own register, so a new request may be taken before it is read.
module deadline_sorted_ready_queue (
	input  logic         clk,
	input  logic         arst_n,
	dsrq_req_if.sink     req,
	dsrq_rsp_if.source   rsp
);

	dsrq_pkg::state_t  state_q, state_d;
	dsrq_pkg::cnt_t    cnt_q, cnt_d;
	dsrq_pkg::cnt_t    pos_q, pos_d;
	dsrq_pkg::cnt_t    pos_m1, pos_m2, pos_p1, cnt_m1;
	logic [dsrq_pkg::DL_W-1:0] dl_q, dl_d;
	logic [dsrq_pkg::ID_W-1:0] id_q, id_d;
	dsrq_pkg::status_t status_q, status_d;
	logic [dsrq_pkg::ID_W-1:0] removed_q, removed_d;

	dsrq_pkg::entry_t  mem [dsrq_pkg::QUEUE_DEPTH];
	dsrq_pkg::entry_t  rd_q;
	dsrq_pkg::entry_t  wd;
	dsrq_pkg::idx_t    wa, ra;
	logic              we, re;

	logic              req_fire;
	logic              rsp_load;
	logic              rsp_valid_q;
	dsrq_pkg::status_t rsp_status_q;
	logic [dsrq_pkg::ID_W-1:0]  rsp_removed_q, rsp_head_id_q;
	logic              rsp_head_valid_q;
	logic [dsrq_pkg::DL_W-1:0]  rsp_head_dl_q;
	logic [dsrq_pkg::OCC_W-1:0] rsp_occ_q;

	assign req.ready = (state_q == dsrq_pkg::ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == dsrq_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign pos_m1 = pos_q - dsrq_pkg::cnt_t'(1);
	assign pos_m2 = pos_q - dsrq_pkg::cnt_t'(2);
	assign pos_p1 = pos_q + dsrq_pkg::cnt_t'(1);
	assign cnt_m1 = cnt_q - dsrq_pkg::cnt_t'(1);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		dl_d      = dl_q;
		id_d      = id_q;
		status_d  = status_q;
		removed_d = removed_q;
		we        = 1'b0;
		wa        = '0;
		wd        = '{deadline: dl_q, id: id_q};
		re        = 1'b0;
		ra        = '0;
		case (state_q)
			dsrq_pkg::ST_IDLE: begin
				if (req_fire) begin
					dl_d      = req.deadline;
					id_d      = req.task_id;
					removed_d = '0;
					status_d  = dsrq_pkg::STATUS_DONE;
					if (req.cmd == dsrq_pkg::CMD_INSERT) begin
						if (cnt_q == dsrq_pkg::cnt_t'(dsrq_pkg::QUEUE_DEPTH)) begin
							status_d = dsrq_pkg::STATUS_FULL;
							state_d  = dsrq_pkg::ST_HEAD;
						end else begin
							// The hole starts at the tail and moves towards the head.
							pos_d   = cnt_q;
							re      = (cnt_q != '0);
							ra      = cnt_m1[dsrq_pkg::IDX_W-1:0];
							state_d = dsrq_pkg::ST_WALK;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = dsrq_pkg::STATUS_EMPTY;
							state_d  = dsrq_pkg::ST_HEAD;
						end else begin
							re      = 1'b1;
							ra      = '0;
							state_d = dsrq_pkg::ST_RHEAD;
						end
					end
				end
			end
			dsrq_pkg::ST_WALK: begin
				// rd_q holds the entry just in front of the hole when pos_q is non-zero.
				we = 1'b1;
				wa = pos_q[dsrq_pkg::IDX_W-1:0];
				if (pos_q == '0 || !(rd_q.deadline > dl_q)) begin
					cnt_d   = cnt_q + dsrq_pkg::cnt_t'(1);
					state_d = dsrq_pkg::ST_HEAD;
				end else begin
					wd    = rd_q;
					pos_d = pos_m1;
					re    = (pos_q >= dsrq_pkg::cnt_t'(2));
					ra    = pos_m2[dsrq_pkg::IDX_W-1:0];
				end
			end
			dsrq_pkg::ST_RHEAD: begin
				removed_d = rd_q.id;
				if (cnt_q == dsrq_pkg::cnt_t'(1)) begin
					cnt_d   = cnt_m1;
					state_d = dsrq_pkg::ST_HEAD;
				end else begin
					re      = 1'b1;
					ra      = dsrq_pkg::idx_t'(1);
					pos_d   = dsrq_pkg::cnt_t'(1);
					state_d = dsrq_pkg::ST_SHIFT;
				end
			end
			dsrq_pkg::ST_SHIFT: begin
				we = 1'b1;
				wa = pos_m1[dsrq_pkg::IDX_W-1:0];
				wd = rd_q;
				if (pos_p1 < cnt_q) begin
					re    = 1'b1;
					ra    = pos_p1[dsrq_pkg::IDX_W-1:0];
					pos_d = pos_p1;
				end else begin
					cnt_d   = cnt_m1;
					state_d = dsrq_pkg::ST_HEAD;
				end
			end
			dsrq_pkg::ST_HEAD: begin
				re      = 1'b1;
				ra      = '0;
				state_d = dsrq_pkg::ST_DONE;
			end
			dsrq_pkg::ST_DONE: begin
				if (rsp_load) begin
					state_d = dsrq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsrq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsrq_pkg::ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		dl_q      <= dl_d;
		id_q      <= id_d;
		status_q  <= status_d;
		removed_q <= removed_d;
		if (rsp_load) begin
			rsp_status_q     <= status_q;
			rsp_removed_q    <= removed_q;
			rsp_head_valid_q <= (cnt_q != '0);
			rsp_head_id_q    <= (cnt_q != '0) ? rd_q.id : '0;
			rsp_head_dl_q    <= (cnt_q != '0) ? rd_q.deadline : '0;
			rsp_occ_q        <= dsrq_pkg::OCC_W'(cnt_q);
		end
	end

	// Entry store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_id    = rsp_removed_q;
	assign rsp.head_valid    = rsp_head_valid_q;
	assign rsp.head_id       = rsp_head_id_q;
	assign rsp.head_deadline = rsp_head_dl_q;
	assign rsp.occupancy     = rsp_occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dsrq_pkg::cnt_t'(dsrq_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + dsrq_pkg::cnt_t'(1) ||
		cnt_q + dsrq_pkg::cnt_t'(1) == $past(cnt_q))
		else $error("queue count moved by more than one");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsrq_pkg::ST_IDLE) |=> (cnt_q == $past(cnt_q)))
		else $error("queue count changed outside an operation");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && status_q == dsrq_pkg::STATUS_FULL) |->
		(cnt_q == dsrq_pkg::cnt_t'(dsrq_pkg::QUEUE_DEPTH)))
		else $error("full status with room left");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && status_q == dsrq_pkg::STATUS_EMPTY) |->
		(cnt_q == '0 && removed_q == '0))
		else $error("empty status on a non-empty queue");

endmodule

### tb/sv/tb_deadline_sorted_ready_queue.sv
// ----------------------------------------------------------------------------
// tb_deadline_sorted_ready_queue: self-checking bench for the EDF ready queue
// Directed and random insert/remove requests feed a software copy of the
// deadline-ordered list. Every response is checked against the oldest
// prediction under random valid/ready idling and a long response stall.
// ----------------------------------------------------------------------------
module tb_deadline_sorted_ready_queue;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 250;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 275;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		dsrq_pkg::status_t                status;
		logic [dsrq_pkg::ID_W-1:0]        removed_id;
		logic                             head_valid;
		logic [dsrq_pkg::ID_W-1:0]        head_id;
		logic [dsrq_pkg::DL_W-1:0]        head_deadline;
		logic [dsrq_pkg::OCC_W-1:0]       occupancy;
	} head_report_t;

	// Software copy of the deadline-ordered list and the responses it predicts.
	class ready_queue_scoreboard;
		logic [dsrq_pkg::DL_W-1:0] held_deadline[dsrq_pkg::QUEUE_DEPTH];
		logic [dsrq_pkg::ID_W-1:0] held_id[dsrq_pkg::QUEUE_DEPTH];
		int unsigned     held_count = 0;
		head_report_t    expected_reports[$];
		int unsigned     error_count = 0;

		function void note_request(dsrq_pkg::cmd_t cmd, logic [dsrq_pkg::ID_W-1:0] id,
			logic [dsrq_pkg::DL_W-1:0] dl);
			head_report_t want;
			int unsigned  pos;
			int unsigned  k;
			want.status = dsrq_pkg::STATUS_DONE;
			want.removed_id = '0;
			if (cmd == dsrq_pkg::CMD_INSERT) begin
				if (held_count >= dsrq_pkg::QUEUE_DEPTH) begin
					want.status = dsrq_pkg::STATUS_FULL;
				end else begin
					// Equal deadlines go behind the tasks already held.
					pos = 0;
					while (pos < held_count && held_deadline[pos] <= dl)
						pos++;
					for (k = held_count; k > pos; k--) begin
						held_deadline[k] = held_deadline[k-1];
						held_id[k] = held_id[k-1];
					end
					held_deadline[pos] = dl;
					held_id[pos] = id;
					held_count++;
				end
			end else begin
				if (held_count == 0) begin
					want.status = dsrq_pkg::STATUS_EMPTY;
				end else begin
					want.removed_id = held_id[0];
					for (k = 1; k < held_count; k++) begin
						held_deadline[k-1] = held_deadline[k];
						held_id[k-1] = held_id[k];
					end
					held_count--;
				end
			end
			want.head_valid = (held_count != 0);
			want.head_id = (held_count != 0) ? held_id[0] : '0;
			want.head_deadline = (held_count != 0) ? held_deadline[0] : '0;
			want.occupancy = dsrq_pkg::OCC_W'(held_count);
			expected_reports.push_back(want);
		endfunction

		function void check_response(head_report_t got);
			head_report_t want;
			if (expected_reports.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display({"tb: response with no request outstanding: ",
						"st=%0d rm=%02h hv=%0b id=%02h dl=%08h occ=%0d"},
						got.status, got.removed_id, got.head_valid, got.head_id,
						got.head_deadline, got.occupancy);
				return;
			end
			want = expected_reports.pop_front();
			if (got.status !== want.status || got.removed_id !== want.removed_id ||
			    got.head_valid !== want.head_valid || got.head_id !== want.head_id ||
			    got.head_deadline !== want.head_deadline ||
			    got.occupancy !== want.occupancy) begin
				error_count++;
				if (error_count <= REPORT_LIMIT) begin
					$display({"tb: mismatch at %0t: expected ",
						"st=%0d rm=%02h hv=%0b id=%02h dl=%08h occ=%0d"},
						$realtime, want.status, want.removed_id, want.head_valid,
						want.head_id, want.head_deadline, want.occupancy);
					$display({"tb:                  actual   ",
						"st=%0d rm=%02h hv=%0b id=%02h dl=%08h occ=%0d"},
						got.status, got.removed_id, got.head_valid, got.head_id,
						got.head_deadline, got.occupancy);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dsrq_req_if req_ch();
	dsrq_rsp_if rsp_ch();

	deadline_sorted_ready_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ready_queue_scoreboard sb;

	int send_idle_pct = 0;
	int rsp_idle_pct = 0;
	int hold_bursts_wanted = 0;
	int stall_cycles = 0;

	always #(CLK_PERIOD/2) clk = ~clk;

	// Deadlines cluster on a few small values so that ties are common.
	function automatic logic [dsrq_pkg::DL_W-1:0] random_deadline();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return dsrq_pkg::DL_W'($urandom_range(0, 15));
			4:          return '0;
			5:          return '1;
			default:    return dsrq_pkg::DL_W'($urandom);
		endcase
	endfunction

	task automatic send_request(dsrq_pkg::cmd_t cmd, logic [dsrq_pkg::ID_W-1:0] id,
		logic [dsrq_pkg::DL_W-1:0] dl);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.task_id <= id;
		req_ch.deadline <= dl;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(cmd, id, dl);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	task automatic wait_for_responses();
		while (sb.expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// Bursts of mostly inserts or mostly removes walk the queue between full and empty.
	task automatic run_random_phase(int items);
		int   burst_left;
		int   insert_pct;
		dsrq_pkg::cmd_t cmd;
		burst_left = 0;
		insert_pct = 50;
		repeat (items) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(4, 40);
				case ($urandom_range(0, 2))
					0:       insert_pct = 85;
					1:       insert_pct = 50;
					default: insert_pct = 20;
				endcase
			end
			burst_left--;
			cmd = ($urandom_range(0, 99) < insert_pct) ? dsrq_pkg::CMD_INSERT :
				dsrq_pkg::CMD_REMOVE;
			send_request(cmd, dsrq_pkg::ID_W'($urandom_range(0, 255)), random_deadline());
		end
	endtask

	initial begin : rsp_side
		int hold_left;
		int holds_done;
		head_report_t got;
		hold_left = 0;
		holds_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.removed_id = rsp_ch.removed_id;
				got.head_valid = rsp_ch.head_valid;
				got.head_id = rsp_ch.head_id;
				got.head_deadline = rsp_ch.head_deadline;
				got.occupancy = rsp_ch.occupancy;
				sb.check_response(got);
			end
			if (hold_bursts_wanted > holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_deadline_sorted_ready_queue: done, errors");
			$finish;
		end
	end

	initial begin : req_side
		int k;
		sb = new;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= dsrq_pkg::CMD_INSERT;
		req_ch.task_id <= '0;
		req_ch.deadline <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 38;
		rsp_idle_pct = 54;

		// Directed opening: empty remove, extreme ids and deadlines, ties, full queue.
		send_request(dsrq_pkg::CMD_REMOVE, 8'h5A, 32'hDEAD_BEEF);
		send_request(dsrq_pkg::CMD_INSERT, 8'h00, 32'h0000_0000);
		send_request(dsrq_pkg::CMD_INSERT, 8'hFF, 32'hFFFF_FFFF);
		send_request(dsrq_pkg::CMD_INSERT, 8'h11, 32'd100);
		send_request(dsrq_pkg::CMD_INSERT, 8'h22, 32'd100);
		send_request(dsrq_pkg::CMD_INSERT, 8'h33, 32'd100);
		send_request(dsrq_pkg::CMD_INSERT, 8'hAA, 32'h0000_0000);
		send_request(dsrq_pkg::CMD_REMOVE, 8'hFF, 32'hFFFF_FFFF);
		send_request(dsrq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000);
		for (k = 0; k < dsrq_pkg::QUEUE_DEPTH - 4; k++)
			send_request(dsrq_pkg::CMD_INSERT, dsrq_pkg::ID_W'(8'h40 + k),
				(k[0] ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ dsrq_pkg::DL_W'(k * 97));
		// The queue is full now: a task that would become the head is dropped.
		send_request(dsrq_pkg::CMD_INSERT, 8'hEE, 32'h0000_0000);
		send_request(dsrq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000);
		send_request(dsrq_pkg::CMD_INSERT, 8'h7F, 32'd100);
		send_request(dsrq_pkg::CMD_INSERT, 8'h80, 32'h8000_0000);

		run_random_phase(PHASE_ITEMS);
		req_ch.valid <= 1'b0;
		wait_for_responses();

		send_idle_pct = 54;
		rsp_idle_pct = 38;
		run_random_phase(PHASE_ITEMS);
		req_ch.valid <= 1'b0;
		wait_for_responses();

		send_idle_pct = 0;
		rsp_idle_pct = 0;
		// Hold the response side off while requests keep coming, so the input stalls.
		hold_bursts_wanted++;
		repeat (10)
			send_request(dsrq_pkg::CMD_INSERT, dsrq_pkg::ID_W'($urandom_range(0, 255)),
				random_deadline());
		run_random_phase(PHASE_ITEMS);
		req_ch.valid <= 1'b0;

		wait_for_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.error_count == 0 && sb.expected_reports.size() == 0)
			$display("tb_deadline_sorted_ready_queue: done, clean");
		else
			$display("tb_deadline_sorted_ready_queue: done, errors");
		$finish;
	end

endmodule

### files.f
rtl/dsrq_pkg.sv
rtl/dsrq_if.sv
rtl/deadline_sorted_ready_queue.sv
tb/sv/tb_deadline_sorted_ready_queue.sv
